// ===== src/fpsc_pkg.sv =====
// Shared types and constants for the frame pacing skip controller.
package fpsc_pkg;

    localparam int TICK_W   = 32;
    localparam int PERIOD_W = 20;
    localparam int SKIP_W   = 4;
    localparam int CNT_W    = SKIP_W + 1;
    localparam int REM_W    = TICK_W - 1;
    localparam int ADDR_W   = 2;
    localparam int CFG_W    = PERIOD_W;
    localparam int OUT_W    = 40;

    localparam logic [ADDR_W-1:0]   REG_FRAME_PERIOD = 2'd0;
    localparam logic [ADDR_W-1:0]   REG_MAX_SKIP     = 2'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 20'd16666;
    localparam logic [SKIP_W-1:0]   MAX_SKIP_RESET = 4'd10;

    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // What kind of result the current word produces.
    typedef enum logic [2:0] {
        RES_RESTART,
        RES_FIRST,
        RES_SKIP,
        RES_WAIT,
        RES_RENDER
    } res_t;

    typedef struct packed {
        logic load;
        logic advance;
        logic div_init;
        logic div_step;
        logic emit;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic first_frame;
        logic owed_nz;
        logic early;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ===== src/frame_pacing_skip_controller.sv =====
// Top level of the frame pacing skip controller.
//
//  Channel   Signals                               Direction  Contents
//  s_*       s_tvalid s_tready s_tdata s_tuser     in         one event word per frame
//  m_*       m_tvalid m_tready m_tdata             out        one pacing decision per event
//  cfg_*     cfg_we cfg_addr cfg_data              in         frame_period, max_skip
//
// A restart or first-frame word passes from acceptance through the dispatch state to the
// result register; a skip or wait decision also passes the check state. A render also
// runs the divider, which subtracts the frame period from the lateness once per cycle,
// at most max_skip + 1 times. The next word is accepted once the result is registered,
// even while the receiver stalls it; a second result waits for the first.
// Reset loads frame_period 16666, max_skip 10 and arms the first-frame flag.
module frame_pacing_skip_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    // Event input.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] now_ticks
    input  logic                          s_tuser,   // [0] kind
    // Decision output.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [0] skip_frame, [1] must_wait,
                                                     // [33:2] wait_until, [39:34] zero
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [fpsc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [fpsc_pkg::CFG_W-1:0]    cfg_data
);
    import fpsc_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    logic              out_skip;
    logic              out_wait;
    logic [TICK_W-1:0] out_until;

    // The controller sequences each word; the datapath holds all pacing state.
    fpsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_kind   (s_tuser),
        .in_now    (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_skip  (out_skip),
        .out_wait  (out_wait),
        .out_until (out_until)
    );

    // Pack the decision fields, lowest field first, zero fill to a byte boundary.
    assign m_tdata = {{(OUT_W-TICK_W-2){1'b0}}, out_until, out_wait, out_skip};

endmodule

// ===== src/fpsc_ctrl.sv =====
// Controller state machine for the frame pacing skip controller.
module fpsc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fpsc_pkg::sts_t sts,
    output fpsc_pkg::cmd_t cmd
);
    import fpsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_DIVIDE,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        cmd          = '0;
        cmd.res      = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.kind == KIND_RESTART)
                begin
                    res_next   = RES_RESTART;
                    state_next = ST_RESULT;
                end
                else if (sts.first_frame)
                begin
                    res_next   = RES_FIRST;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.owed_nz)
                begin
                    res_next   = RES_SKIP;
                    state_next = ST_RESULT;
                end
                else if (sts.early)
                begin
                    res_next   = RES_WAIT;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    res_next   = RES_RENDER;
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= RES_RESTART;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

// ===== src/fpsc_dp.sv =====
// Datapath for the frame pacing skip controller: pacing state, divider, output register.
module fpsc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fpsc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [fpsc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_kind,
    input  logic [fpsc_pkg::TICK_W-1:0]   in_now,
    input  fpsc_pkg::cmd_t                cmd,
    output fpsc_pkg::sts_t                sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_skip,
    output logic                          out_wait,
    output logic [fpsc_pkg::TICK_W-1:0]   out_until
);
    import fpsc_pkg::*;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [SKIP_W-1:0]   max_skip_reg, max_skip_next;
    logic                first_reg, first_next;
    logic [TICK_W-1:0]   deadline_reg, deadline_next;
    logic [SKIP_W-1:0]   owed_reg, owed_next;
    logic                kind_reg;
    logic [TICK_W-1:0]   now_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                valid_reg, valid_next;
    logic                skip_reg;
    logic                wait_reg;
    logic [TICK_W-1:0]   until_reg;

    logic [TICK_W-1:0]   diff;
    logic                fits;
    logic                over;

    assign diff = now_reg - deadline_reg;
    assign fits = ({{(REM_W-PERIOD_W){1'b0}}, period_reg} <= rem_reg);
    assign over = (cnt_reg > {1'b0, max_skip_reg});

    assign sts.kind        = kind_reg;
    assign sts.first_frame = first_reg;
    assign sts.owed_nz     = (owed_reg != '0);
    assign sts.early       = diff[TICK_W-1];
    assign sts.div_done    = over || !fits;
    assign sts.out_free    = !valid_reg || out_ready;

    assign out_valid = valid_reg;
    assign out_skip  = skip_reg;
    assign out_wait  = wait_reg;
    assign out_until = until_reg;

    always_comb
    begin
        period_next   = period_reg;
        max_skip_next = max_skip_reg;
        first_next    = first_reg;
        deadline_next = deadline_reg;
        owed_next     = owed_reg;
        valid_next    = valid_reg && !out_ready;

        if (cfg_we)
        begin
            if (cfg_addr == REG_FRAME_PERIOD)
            begin
                period_next = cfg_data[PERIOD_W-1:0];
            end
            else if (cfg_addr == REG_MAX_SKIP)
            begin
                max_skip_next = cfg_data[SKIP_W-1:0];
            end
        end

        if (cmd.advance)
        begin
            deadline_next = deadline_reg + {{(TICK_W-PERIOD_W){1'b0}}, period_reg};
        end

        if (cmd.emit)
        begin
            valid_next = 1'b1;
            case (cmd.res)
                RES_RESTART:
                begin
                    first_next = 1'b1;
                end
                RES_FIRST:
                begin
                    first_next    = 1'b0;
                    deadline_next = now_reg;
                end
                RES_SKIP:
                begin
                    owed_next = owed_reg - 1'b1;
                end
                RES_RENDER:
                begin
                    if (over)
                    begin
                        owed_next  = max_skip_reg;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        owed_next = cnt_reg[SKIP_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RESET;
            max_skip_reg <= MAX_SKIP_RESET;
            first_reg    <= 1'b1;
            deadline_reg <= '0;
            owed_reg     <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            period_reg   <= period_next;
            max_skip_reg <= max_skip_next;
            first_reg    <= first_next;
            deadline_reg <= deadline_next;
            owed_reg     <= owed_next;
            valid_reg    <= valid_next;
        end
    end

    // Payload registers: input capture, divider and result word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            now_reg  <= in_now;
        end
        if (cmd.div_init)
        begin
            rem_reg <= diff[REM_W-1:0];
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_reg - {{(REM_W-PERIOD_W){1'b0}}, period_reg};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            skip_reg  <= (cmd.res == RES_SKIP);
            wait_reg  <= (cmd.res == RES_WAIT);
            until_reg <= (cmd.res == RES_FIRST) ? now_reg : deadline_reg;
        end
    end

endmodule

// ===== tb/frame_pacing_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts and compares the pacing decisions of the frame pacing skip controller.
module frame_pacing_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,    // [31:0] now_ticks
    input  logic                          s_tuser,    // [0] kind
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [39:0]                   m_tdata,    // [0] skip_frame, [1] must_wait,
                                                      // [33:2] wait_until
    input  logic                          cfg_we,
    input  logic [fpsc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [fpsc_pkg::CFG_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            outstanding
);
    import fpsc_pkg::*;

    typedef struct packed {
        logic              skip_frame;
        logic              must_wait;
        logic [TICK_W-1:0] wait_until;
    } decision_t;

    logic [PERIOD_W-1:0] period_q;
    logic [SKIP_W-1:0]   skip_limit_q;
    logic                armed_q;
    logic [TICK_W-1:0]   deadline_q;
    logic [SKIP_W-1:0]   owed_q;
    decision_t           decision_q[$];
    int                  fail_count;

    // Works out the decision for one event word and updates the pacing state.
    function automatic decision_t pace_event(input logic kind, input logic [TICK_W-1:0] now);
        decision_t         d;
        logic [TICK_W-1:0] late;
        logic [TICK_W-1:0] periods;
        d = '0;
        if (kind == KIND_RESTART)
        begin
            armed_q = 1'b1;
        end
        else if (armed_q)
        begin
            armed_q    = 1'b0;
            deadline_q = now;
        end
        else
        begin
            deadline_q = deadline_q + TICK_W'(period_q);
            if (owed_q != '0)
            begin
                owed_q       = owed_q - 1'b1;
                d.skip_frame = 1'b1;
            end
            else
            begin
                late = now - deadline_q;
                if (late[TICK_W-1])
                begin
                    d.must_wait = 1'b1;
                end
                else
                begin
                    periods = (period_q == '0) ? '1 : late / TICK_W'(period_q);
                    if (periods > TICK_W'(skip_limit_q))
                    begin
                        owed_q  = skip_limit_q;
                        armed_q = 1'b1;
                    end
                    else
                    begin
                        owed_q = periods[SKIP_W-1:0];
                    end
                end
            end
        end
        d.wait_until = deadline_q;
        return d;
    endfunction

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("ERROR at %0t: %s expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        if (!rst_n)
        begin
            period_q     = PERIOD_RESET;
            skip_limit_q = MAX_SKIP_RESET;
            armed_q      = 1'b1;
            deadline_q   = '0;
            owed_q       = '0;
            fail_count   = 0;
            decision_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_FRAME_PERIOD)
                    period_q = cfg_data[PERIOD_W-1:0];
                else if (cfg_addr == REG_MAX_SKIP)
                    skip_limit_q = cfg_data[SKIP_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (decision_q.size() == 0)
                begin
                    flag("word with nothing pending, wait_until", '0, m_tdata[33:2]);
                end
                else
                begin
                    want = decision_q.pop_front();
                    if (m_tdata[0] !== want.skip_frame)
                        flag("skip_frame", 32'(want.skip_frame), 32'(m_tdata[0]));
                    if (m_tdata[1] !== want.must_wait)
                        flag("must_wait", 32'(want.must_wait), 32'(m_tdata[1]));
                    if (m_tdata[33:2] !== want.wait_until)
                        flag("wait_until", want.wait_until, m_tdata[33:2]);
                    if (m_tdata[39:34] !== 6'd0)
                        flag("padding", '0, 32'(m_tdata[39:34]));
                end
            end
            if (s_tvalid && s_tready)
                decision_q.push_back(pace_event(s_tuser, s_tdata));
            mismatches  <= fail_count;
            outstanding <= decision_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the testbench: stimulus, configuration and verdict for the frame pacing skip controller.
module tb;

    import fpsc_pkg::*;

    // Spare register indexes beyond the two real registers; writes there must do nothing.
    localparam logic [ADDR_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [ADDR_W-1:0] REG_SPARE_B = 2'd3;

    // A decision is bounded by the controller states, the divider and the stalls on either
    // side, so reaching STALL_LIMIT without any accepted word means the block has hung.
    localparam int STALL_LIMIT  = 400;
    // Cycles to watch for stray output words after the last expected one.
    localparam int DRAIN_CYCLES = 40;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata  = '0;     // [31:0] now_ticks
    logic                s_tuser  = 1'b0;   // [0] kind
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;           // [0] skip_frame, [1] must_wait, [33:2] wait_until
    logic                cfg_we   = 1'b0;
    logic [ADDR_W-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_data = '0;

    int                  mismatches;
    int                  outstanding;

    // When set, neither side inserts idle cycles.
    bit                  calm = 1'b0;
    // Running microsecond clock used to build realistic event sequences.
    logic [31:0]         clock_now;

    frame_pacing_skip_controller i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    frame_pacing_checker pacing_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver idles in roughly one cycle of ten, in short random bursts, so that
    // the output register fills up while the divider is busy on the next word.
    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < 3)
            begin
                hold = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("frame_pacing_skip_controller: mismatch");
        $finish;
    end

    // Presents one event word, with an occasional idle gap first, and returns at the
    // edge where it is accepted. The valid stays high so back-to-back words need no
    // extra assignment in the same step.
    task automatic send_event(input logic kind, input logic [31:0] now);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 10)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= now;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic sender_off();
        s_tvalid <= 1'b0;
    endtask

    // Waits until every expected decision has come out of the block.
    task automatic wait_idle();
        do @(posedge clk); while (outstanding != 0);
    endtask

    // One register write per cycle; the caller lowers the write enable afterwards.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Writes both registers. The max_skip word carries random junk above its four bits,
    // which the block must ignore, and the spare indexes optionally get random writes.
    task automatic configure(input logic [PERIOD_W-1:0] period, input logic [SKIP_W-1:0] limit,
                             input bit spare);
        logic [CFG_W-1:0] word;
        word = CFG_W'($urandom);
        word[SKIP_W-1:0] = limit;
        write_reg(REG_FRAME_PERIOD, period);
        write_reg(REG_MAX_SKIP, word);
        if (spare)
        begin
            write_reg(REG_SPARE_A, CFG_W'($urandom));
            write_reg(REG_SPARE_B, CFG_W'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    // One phase of random traffic under one register setting. Most words are frame
    // requests on a clock that moves forward by about one period, by less (early frames),
    // or by several periods (late frames that owe skips or hit the clamp). The rest are
    // restarts and frame requests at random times.
    task automatic run_phase(input logic [PERIOD_W-1:0] period, input logic [SKIP_W-1:0] limit,
                             input int count, input logic [31:0] start, input bit spare,
                             input bit pause_mid);
        int          p;
        int          roll;
        longint      step;
        logic        kind;
        logic [31:0] now;
        p = period;
        wait_idle();
        configure(period, limit, spare);
        clock_now = start;
        for (int n = 0; n < count; n++)
        begin
            // Hold the sender until the block has drained, then carry on.
            if (pause_mid && n == count / 2)
            begin
                sender_off();
                wait_idle();
            end
            kind = KIND_FRAME;
            roll = $urandom_range(0, 99);
            if (roll < 5)
            begin
                kind = KIND_RESTART;
                now  = $urandom;
            end
            else if (roll < 10)
            begin
                now = $urandom;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (p == 0)
                    step = $urandom_range(0, 2000);
                else if (roll < 40)
                    step = p - p / 8 + $urandom_range(0, p / 4);
                else if (roll < 65)
                    step = $urandom_range(0, p / 2);
                else if (roll < 90)
                    step = longint'(p) * $urandom_range(2, limit + 2) + $urandom_range(0, p - 1);
                else
                    step = longint'(p) * (limit + $urandom_range(2, 6));
                clock_now = clock_now + step[31:0];
                now = clock_now;
            end
            send_event(kind, now);
        end
        sender_off();
    endtask

    initial
    begin
        logic [31:0] base;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the reset settings (period 16666, max_skip 10).
        send_event(KIND_FRAME, 32'd0);                  // first frame loads the deadline
        send_event(KIND_FRAME, 32'd0);                  // before the deadline: wait
        send_event(KIND_FRAME, 32'd33332);              // exactly on the deadline: render
        send_event(KIND_FRAME, 32'd99996);              // three periods late: owes three
        send_event(KIND_FRAME, 32'd0);                  // pays one owed frame off
        send_event(KIND_RESTART, 32'hFFFF_FFFF);        // restart keeps the owed frames
        send_event(KIND_FRAME, 32'hFFFF_FFFF);          // first frame at the top of the clock
        send_event(KIND_FRAME, 32'd0);                  // owed skip, deadline wraps
        send_event(KIND_FRAME, 32'hFFFF_FFFF);          // last owed skip
        send_event(KIND_FRAME, 32'h0000_8000);          // early across the wrap
        sender_off();
        wait_idle();

        // A small clamp makes the owed-equal and owed-over cases short.
        configure(20'd16666, 4'd2, 1'b1);
        send_event(KIND_FRAME, 32'd99995);              // late by exactly max_skip periods
        send_event(KIND_FRAME, 32'd0);
        send_event(KIND_FRAME, 32'd0);
        send_event(KIND_FRAME, 32'd166659);             // one period over the clamp: re-arm
        base = 32'h7FFF_0000;
        send_event(KIND_FRAME, base);                   // first frame after the clamp
        send_event(KIND_FRAME, 32'd0);                  // the clamped frames are skipped
        send_event(KIND_FRAME, 32'd0);
        // Lateness of exactly two to the 31st counts as early.
        send_event(KIND_FRAME, base + 32'd49998 + 32'h8000_0000);
        // The largest lateness that still counts as late hits the clamp.
        send_event(KIND_FRAME, base + 32'd66664 + 32'h7FFF_FFFF);
        send_event(KIND_RESTART, 32'd0);
        send_event(KIND_FRAME, 32'h1234_5678);
        sender_off();

        // Random phases across the register range, extremes included.
        run_phase(20'd16666, 4'd10, 60, $urandom, 1'b0, 1'b0);
        run_phase(20'd1, 4'd0, 50, $urandom, 1'b1, 1'b0);
        run_phase(20'd1000000, 4'd15, 60, 32'hFFF0_0000, 1'b0, 1'b1);
        run_phase(20'd0, 4'd3, 40, $urandom, 1'b0, 1'b0);
        run_phase(20'hFFFFF, 4'd15, 50, $urandom, 1'b1, 1'b0);

        // A stretch where neither side idles at all.
        wait_idle();
        calm = 1'b1;
        run_phase(PERIOD_W'($urandom_range(1, 50000)), SKIP_W'($urandom_range(0, 15)), 80,
                  $urandom, 1'b0, 1'b0);
        wait_idle();
        calm = 1'b0;

        run_phase(PERIOD_W'($urandom_range(100, 20000)), SKIP_W'($urandom_range(0, 15)), 90,
                  $urandom, 1'b0, 1'b0);

        // Drain, then keep watching for stray words before the verdict.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("frame_pacing_skip_controller: match");
        else
            $display("frame_pacing_skip_controller: mismatch");
        $finish;
    end

endmodule
